// File: design/ahci_command_descriptor_builder_assert.svh
// Assertion macros for the AHCI command descriptor builder.
// Uses clk_i and rst_ni of the module that includes this header.
`ifndef AHCI_COMMAND_DESCRIPTOR_BUILDER_ASSERT_SVH
`define AHCI_COMMAND_DESCRIPTOR_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS
`define ACDB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ACDB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACDB_ASSERT_IMP(lbl, ante, cons, msg)
`define ACDB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/acdb_pkg.sv
// Shared constants, payload types and control types of the command descriptor builder.
// No dependencies.
package acdb_pkg;

  localparam int MAX_ENTRIES     = 8;
  localparam int ENTRY_MAX_BYTES = 4194304;
  localparam int SECTOR_BYTES    = 512;

  localparam logic [7:0] FIS_DEVICE_LBA = 8'h40;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ZERO  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // Remaining bytes of a command: sector count times sector size.
  localparam int LEFT_W  = 16 + $clog2(SECTOR_BYTES);
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TOTAL_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W   = 32;

  typedef struct packed {
    logic [47:0] start_block;
    logic [15:0] sector_total;
    logic [63:0] buffer_base;
    logic [7:0]  ata_opcode;
    logic        host_to_device;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] entry_address;
    logic [21:0] entry_bytes_minus_one;
    logic        entry_interrupt;
    logic [2:0]  entry_number;
    logic [3:0]  entry_total;
    logic [7:0]  fis_opcode;
    logic [47:0] fis_block;
    logic [15:0] fis_count;
    logic [7:0]  fis_device_byte;
    logic        write_direction;
    logic        last;
  } ent_t;

  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic show_status;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic fin;
  } dp_stat_t;

endpackage

// File: design/acdb_req_if.sv
// Request channel: valid/ready handshake carrying one disk command.
// Depends on acdb_pkg.
interface acdb_req_if;
  logic            valid;
  logic            ready;
  acdb_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/acdb_ent_if.sv
// Entry channel: valid/ready handshake carrying one scatter entry or status result.
// Depends on acdb_pkg.
interface acdb_ent_if;
  logic            valid;
  logic            ready;
  acdb_pkg::ent_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/ahci_command_descriptor_builder.sv
// AHCI command descriptor builder: one disk command in, its scatter entries out.
// Instantiates acdb_regs, acdb_ctrl and acdb_dp; uses acdb_pkg and both channel interfaces.
// Usage:
//   req_i carries one command (start block, sector count, buffer base, opcode,
//   direction) under a valid/ready handshake. ent_o returns the scatter entries
//   of that command in address order, one transfer per entry, each piece at
//   most ENTRY_MAX_BYTES long and at most MAX_ENTRIES of them; last marks the
//   final one. A zero count or a range past a nonzero device_blocks gives a
//   single status result instead.
//   device_blocks is written through the APB-style port at byte address 0.
// Timing:
//   The command is registered in its accept cycle, checked and counted in the
//   next, and the first entry is valid on the cycle after that. Entries then
//   follow one per cycle while the receiver holds ready high. A new command is
//   accepted once the last result has been transferred; the controller handles
//   one command at a time.
// Reset and stalls:
//   Reset returns the controller to idle and clears device_blocks to zero.
//   When the receiver holds ready low the current result stays on ent_o
//   unchanged until it is transferred.
module ahci_command_descriptor_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  acdb_req_if.sink    req_i,
  acdb_ent_if.source  ent_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0]        dev_blocks;
  acdb_pkg::dp_cmd_t  dp_cmd;
  acdb_pkg::dp_stat_t dp_stat;

  acdb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .dev_blocks_o (dev_blocks)
  );

  acdb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (ent_o.valid),
    .out_ready_i (ent_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  acdb_dp u_dp (
    .clk_i        (clk_i),
    .dev_blocks_i (dev_blocks),
    .req_i        (req_i.payload),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .ent_o        (ent_o.payload)
  );

endmodule

// File: design/acdb_regs.sv
// APB-style configuration register holding the device capacity.
// Depends on nothing but its ports.
module acdb_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [47:0] dev_blocks_o
);

  logic [47:0] dev_blocks_q, dev_blocks_d;
  logic        wr_en;

  // Register 0 sits at byte address 0; bit 3 selects the next 8-byte slot.
  assign wr_en = psel && penable && pwrite && !paddr[3];

  always_comb begin
    dev_blocks_d = dev_blocks_q;
    if (wr_en) begin
      dev_blocks_d = pwdata[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_blocks_q <= 48'd0;
    end else begin
      dev_blocks_q <= dev_blocks_d;
    end
  end

  assign prdata       = paddr[3] ? 64'd0 : {16'd0, dev_blocks_q};
  assign pready       = 1'b1;
  assign dev_blocks_o = dev_blocks_q;

endmodule

// File: design/acdb_dp.sv
// Datapath: request registers, range and zero checks, entry count and the
// address/length walk over the buffer. Depends on acdb_pkg.
module acdb_dp (
  input  logic               clk_i,
  input  logic [47:0]        dev_blocks_i,
  input  acdb_pkg::req_t     req_i,
  input  acdb_pkg::dp_cmd_t  cmd_i,
  output acdb_pkg::dp_stat_t stat_o,
  output acdb_pkg::ent_t     ent_o
);

  localparam logic [acdb_pkg::LEFT_W-1:0] EntryMax =
    acdb_pkg::LEFT_W'(acdb_pkg::ENTRY_MAX_BYTES);

  acdb_pkg::req_t                  req_q;
  logic [acdb_pkg::LEFT_W-1:0]     left_q;
  logic [63:0]                     addr_q;
  logic [acdb_pkg::IDX_W-1:0]      idx_q;
  logic [acdb_pkg::TOTAL_W-1:0]    total_q;
  logic [1:0]                      status_q;

  logic                            zero_cnt;
  logic                            out_range;
  logic [48:0]                     end_block;
  logic [acdb_pkg::MAX_ENTRIES-1:0] above_k;
  logic [acdb_pkg::TOTAL_W-1:0]    total_calc;
  logic [acdb_pkg::LEFT_W-1:0]     take;

  assign zero_cnt  = (req_q.sector_total == 16'd0);
  assign end_block = {1'b0, req_q.start_block} + 49'(req_q.sector_total);
  assign out_range = (dev_blocks_i != 48'd0) && (end_block > {1'b0, dev_blocks_i});

  // Entry count as a thermometer: entry k exists when more than k full pieces remain.
  always_comb begin
    for (int k = 0; k < acdb_pkg::MAX_ENTRIES; k++) begin
      above_k[k] = acdb_pkg::CMP_W'(left_q) > acdb_pkg::CMP_W'(k * acdb_pkg::ENTRY_MAX_BYTES);
    end
  end
  assign total_calc = acdb_pkg::TOTAL_W'($countones(above_k));

  assign take = (left_q > EntryMax) ? EntryMax : left_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i;
      left_q <= acdb_pkg::LEFT_W'(req_i.sector_total) *
                acdb_pkg::LEFT_W'(acdb_pkg::SECTOR_BYTES);
      addr_q <= req_i.buffer_base;
      idx_q  <= '0;
    end else if (cmd_i.check) begin
      total_q <= total_calc;
      if (zero_cnt) begin
        status_q <= acdb_pkg::STATUS_ZERO;
      end else if (out_range) begin
        status_q <= acdb_pkg::STATUS_RANGE;
      end else begin
        status_q <= acdb_pkg::STATUS_OK;
      end
    end else if (cmd_i.step) begin
      addr_q <= addr_q + 64'(take);
      left_q <= left_q - take;
      idx_q  <= idx_q + acdb_pkg::IDX_W'(1);
    end
  end

  assign stat_o.reject = zero_cnt || out_range;
  assign stat_o.fin    = ((acdb_pkg::TOTAL_W'(idx_q) + acdb_pkg::TOTAL_W'(1)) == total_q);

  always_comb begin
    ent_o = '0;
    if (cmd_i.show_status) begin
      ent_o.status = status_q;
      ent_o.last   = 1'b1;
    end else begin
      ent_o.status                = acdb_pkg::STATUS_OK;
      ent_o.entry_address         = addr_q;
      ent_o.entry_bytes_minus_one = 22'(take - acdb_pkg::LEFT_W'(1));
      ent_o.entry_interrupt       = stat_o.fin;
      ent_o.entry_number          = 3'(idx_q);
      ent_o.entry_total           = 4'(total_q);
      ent_o.fis_opcode            = req_q.ata_opcode;
      ent_o.fis_block             = req_q.start_block;
      ent_o.fis_count             = req_q.sector_total;
      ent_o.fis_device_byte       = acdb_pkg::FIS_DEVICE_LBA;
      ent_o.write_direction       = req_q.host_to_device;
      ent_o.last                  = stat_o.fin;
    end
  end

endmodule

// File: design/acdb_ctrl.sv
// Controller: sequences accept, check, entry emission and status results.
// Depends on acdb_pkg and the assertion macro header.
`include "ahci_command_descriptor_builder_assert.svh"

module acdb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  acdb_pkg::dp_stat_t stat_i,
  output acdb_pkg::dp_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_STAT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_xfer, out_xfer;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT) || (state_q == S_STAT);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.reject ? S_STAT : S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (stat_i.fin) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      S_STAT: begin
        cmd_o.show_status = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ACDB_ASSERT_NXT(a_accept_to_check, in_xfer, state_q == S_CHECK, "accept did not start a check")
  `ACDB_ASSERT_IMP(a_no_overlap, out_valid_o, !in_ready_o, "input taken while results pending")
  `ACDB_ASSERT_NXT(a_stall_holds, out_valid_o && !out_ready_i, state_q == $past(state_q),
                   "stalled result changed state")
  `ACDB_ASSERT_NXT(a_final_to_idle, (state_q == S_EMIT) && out_xfer && stat_i.fin,
                   state_q == S_IDLE, "final entry did not end the command")

endmodule
